// ----- hdl/drt_pkg.sv -----
// ----------------------------------------------------------------------------
// drt_pkg - shared types and helpers for the dirty rectangle tracker
// Rectangle types, command format, sizes and the overlap/grow arithmetic.
// ----------------------------------------------------------------------------
package drt_pkg;

  localparam int MAX_RECTS = 8;
  localparam int CNT_W     = $clog2(MAX_RECTS + 1);
  localparam int IDX_W     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;

  localparam logic REQ_INVAL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  localparam logic [2:0] CFG_ENABLE   = 3'd0;
  localparam logic [2:0] CFG_SCREEN_W = 3'd1;
  localparam logic [2:0] CFG_SCREEN_H = 3'd2;
  localparam logic [2:0] CFG_BUF_W    = 3'd3;
  localparam logic [2:0] CFG_BUF_H    = 3'd4;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
  } box_t;

  // one queued command: a flush, or an already clipped invalidate
  typedef struct packed {
    logic flush;
    box_t box;
  } cmd_t;

  typedef struct packed {
    logic        enable;
    logic [14:0] screen_w;
    logic [14:0] screen_h;
    logic [14:0] buf_w;
    logic [14:0] buf_h;
  } cfg_t;

  function automatic logic signed [16:0] ext17(input logic signed [15:0] a);
    ext17 = {a[15], a};
  endfunction

  function automatic logic signed [16:0] smin17(input logic signed [16:0] a,
                                                input logic signed [16:0] b);
    smin17 = (a < b) ? a : b;
  endfunction

  function automatic logic signed [16:0] smax17(input logic signed [16:0] a,
                                                input logic signed [16:0] b);
    smax17 = (a > b) ? a : b;
  endfunction

  // a overlaps or touches the span x..x2, y..y2
  function automatic logic touches(input box_t a,
                                   input logic signed [16:0] x,
                                   input logic signed [16:0] y,
                                   input logic signed [16:0] x2,
                                   input logic signed [16:0] y2);
    logic signed [16:0] ax2;
    logic signed [16:0] ay2;
    ax2 = ext17(a.x) + ext17(a.w);
    ay2 = ext17(a.y) + ext17(a.h);
    touches = !(x > ax2 || x2 < ext17(a.x) || y > ay2 || y2 < ext17(a.y));
  endfunction

  // enlarge d to cover x..x2, y..y2 with 16-bit wrapping of the far edges
  function automatic box_t grow(input box_t d,
                                input logic signed [16:0] x,
                                input logic signed [16:0] y,
                                input logic signed [16:0] x2,
                                input logic signed [16:0] y2);
    logic signed [16:0] nx1;
    logic signed [16:0] ny1;
    logic signed [16:0] mx2;
    logic signed [16:0] my2;
    logic signed [16:0] dw;
    logic signed [16:0] dh;
    box_t r;
    nx1 = smin17(x, ext17(d.x));
    ny1 = smin17(y, ext17(d.y));
    mx2 = smax17(x2, ext17(d.x) + ext17(d.w));
    my2 = smax17(y2, ext17(d.y) + ext17(d.h));
    dw  = ext17(mx2[15:0]) - nx1;
    dh  = ext17(my2[15:0]) - ny1;
    r.x = nx1[15:0];
    r.y = ny1[15:0];
    r.w = dw[15:0];
    r.h = dh[15:0];
    grow = r;
  endfunction

endpackage

// ----- hdl/drt_front.sv -----
// ----------------------------------------------------------------------------
// drt_front - request intake
// Accepts requests, clips invalidates to the screen, drops empty ones and drops all invalidates while disabled.
// ----------------------------------------------------------------------------
module drt_front import drt_pkg::*; (
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,
  input  logic        q_full,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic signed [15:0] ix, iy, iw, ih;
  logic signed [16:0] sx2, sy2, cx, cy, cx2, cy2, dw, dh;
  logic               keep;

  assign ix = in_tdata[15:0];
  assign iy = in_tdata[31:16];
  assign iw = in_tdata[47:32];
  assign ih = in_tdata[63:48];

  always_comb begin
    sx2 = ext17(ix) + ext17(iw);
    sy2 = ext17(iy) + ext17(ih);
    cx2 = ext17(sx2[15:0]);
    cy2 = ext17(sy2[15:0]);
    cx  = (ix < 0) ? 17'sd0 : ext17(ix);
    cy  = (iy < 0) ? 17'sd0 : ext17(iy);
    if (cx2 > $signed({2'b00, cfg.screen_w})) begin
      cx2 = $signed({2'b00, cfg.screen_w});
    end
    if (cy2 > $signed({2'b00, cfg.screen_h})) begin
      cy2 = $signed({2'b00, cfg.screen_h});
    end
    dw = ext17(cx2[15:0] - cx[15:0]);
    dh = ext17(cy2[15:0] - cy[15:0]);
    keep = cfg.enable && (iw > 0) && (ih > 0) && (dw > 0) && (dh > 0);
    q_cmd.flush = (in_tuser == REQ_FLUSH);
    q_cmd.box.x = cx[15:0];
    q_cmd.box.y = cy[15:0];
    q_cmd.box.w = dw[15:0];
    q_cmd.box.h = dh[15:0];
  end

  assign in_tready = rst_n && !q_full;
  assign q_push    = in_tvalid && in_tready && (q_cmd.flush || keep);

endmodule

// ----- hdl/drt_queue.sv -----
// ----------------------------------------------------------------------------
// drt_queue - command queue
// Short FIFO between intake and the list sequencer.
// ----------------------------------------------------------------------------
module drt_queue import drt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic nonempty,
  input  logic pop,
  output cmd_t head
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

// ----- hdl/drt_back.sv -----
// ----------------------------------------------------------------------------
// drt_back - list sequencer
// Holds the rectangle list; merges, appends, collapses and flushes it.
// ----------------------------------------------------------------------------
module drt_back import drt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_nonempty,
  input  cmd_t        q_head,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SCAN  = 4'd1;
  localparam logic [3:0] ST_MERGE = 4'd2;
  localparam logic [3:0] ST_MOVE  = 4'd3;
  localparam logic [3:0] ST_COLL  = 4'd4;
  localparam logic [3:0] ST_CFIN  = 4'd5;
  localparam logic [3:0] ST_FL1   = 4'd6;
  localparam logic [3:0] ST_FL2   = 4'd7;
  localparam logic [3:0] ST_FZERO = 4'd8;

  box_t store_r [MAX_RECTS];

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  box_t             cmd_r, cmd_nxt;
  box_t             d_r, d_nxt;
  logic signed [15:0] tx2_r, tx2_nxt, ty2_r, ty2_nxt;
  box_t             f_r, f_nxt;
  logic             fok_r, fok_nxt;

  logic             ov_r, ov_nxt;
  logic [59:0]      od_r, od_nxt;
  logic             ook_r, ook_nxt;
  logic             olast_r, olast_nxt;

  logic [CNT_W-1:0] rd_idx;
  box_t             e;
  logic             we;
  logic [CNT_W-1:0] wa;
  box_t             wd;
  logic             out_free;

  logic signed [16:0] csx, csy;
  logic signed [16:0] cx2, cy2, ex2, ey2, dx2, dy2, t17, bw, bh;
  box_t               g;

  assign out_free   = !ov_r || out_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = {4'd0, od_r};
  assign out_tuser  = ook_r;
  assign out_tlast  = olast_r;

  always_comb begin
    case (state_r)
      ST_MERGE: rd_idx = j_r;
      ST_MOVE:  rd_idx = count_r;
      default:  rd_idx = idx_r;
    endcase
  end
  assign e = store_r[rd_idx[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[wa[IDX_W-1:0]] <= wd;
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    j_nxt     = j_r;
    n_nxt     = n_r;
    cmd_nxt   = cmd_r;
    d_nxt     = d_r;
    tx2_nxt   = tx2_r;
    ty2_nxt   = ty2_r;
    f_nxt     = f_r;
    fok_nxt   = fok_r;
    ov_nxt    = ov_r && !out_tready;
    od_nxt    = od_r;
    ook_nxt   = ook_r;
    olast_nxt = olast_r;
    q_pop     = 1'b0;
    we        = 1'b0;
    wa        = idx_r;
    wd        = d_r;
    bw        = $signed({2'b00, cfg.buf_w});
    bh        = $signed({2'b00, cfg.buf_h});

    // the clipped far edge of the command is its 16-bit wrapped sum
    csx = ext17(cmd_r.x) + ext17(cmd_r.w);
    csy = ext17(cmd_r.y) + ext17(cmd_r.h);
    cx2 = ext17(csx[15:0]);
    cy2 = ext17(csy[15:0]);
    ex2 = ext17(e.x) + ext17(e.w);
    ey2 = ext17(e.y) + ext17(e.h);
    dx2 = ext17(d_r.x) + ext17(d_r.w);
    dy2 = ext17(d_r.y) + ext17(d_r.h);
    g   = d_r;
    t17 = '0;

    case (state_r)
      ST_IDLE: begin
        if (q_nonempty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head.box;
          idx_nxt = '0;
          if (q_head.flush) begin
            n_nxt     = count_r;
            count_nxt = '0;
            if (count_r == '0 || !cfg.enable) begin
              state_nxt = ST_FZERO;
            end else begin
              state_nxt = ST_FL1;
            end
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (idx_r >= count_r) begin
          if (count_r < CNT_W'(MAX_RECTS)) begin
            // append the clipped rectangle
            we        = 1'b1;
            wa        = count_r;
            wd        = cmd_r;
            count_nxt = count_r + 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_COLL;
          end
        end else if (touches(e, ext17(cmd_r.x), ext17(cmd_r.y), cx2, cy2)) begin
          d_nxt     = grow(e, ext17(cmd_r.x), ext17(cmd_r.y), cx2, cy2);
          j_nxt     = idx_r + 1'b1;
          state_nxt = ST_MERGE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_MERGE: begin
        if (j_r >= count_r) begin
          we        = 1'b1;
          wa        = idx_r;
          wd        = d_r;
          state_nxt = ST_IDLE;
        end else if (touches(e, ext17(d_r.x), ext17(d_r.y), dx2, dy2)) begin
          d_nxt     = grow(d_r, ext17(e.x), ext17(e.y), ex2, ey2);
          count_nxt = count_r - 1'b1;
          state_nxt = ST_MOVE;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      ST_MOVE: begin
        // refill the absorbed slot with the last entry
        we        = 1'b1;
        wa        = j_r;
        wd        = e;
        state_nxt = ST_MERGE;
      end
      ST_COLL: begin
        if (idx_r == '0) begin
          g       = e;
          tx2_nxt = ex2[15:0];
          ty2_nxt = ey2[15:0];
        end else begin
          g = d_r;
          if (e.x < d_r.x) g.x = e.x;
          if (e.y < d_r.y) g.y = e.y;
          if ($signed(ex2[15:0]) > tx2_r) tx2_nxt = ex2[15:0];
          if ($signed(ey2[15:0]) > ty2_r) ty2_nxt = ey2[15:0];
        end
        d_nxt = g;
        if (idx_r + 1'b1 >= count_r) begin
          state_nxt = ST_CFIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_CFIN: begin
        g = d_r;
        if (cmd_r.x < d_r.x) g.x = cmd_r.x;
        if (cmd_r.y < d_r.y) g.y = cmd_r.y;
        t17 = (cx2 > ext17(tx2_r)) ? cx2 : ext17(tx2_r);
        t17 = t17 - ext17(g.x);
        g.w = t17[15:0];
        t17 = (cy2 > ext17(ty2_r)) ? cy2 : ext17(ty2_r);
        t17 = t17 - ext17(g.y);
        g.h = t17[15:0];
        we        = 1'b1;
        wa        = '0;
        wd        = g;
        count_nxt = CNT_W'(1);
        state_nxt = ST_IDLE;
      end
      ST_FL1: begin
        f_nxt   = e;
        fok_nxt = (e.w > 0) && (e.h > 0);
        if (e.x < 0) begin
          t17     = ext17(e.w) + ext17(e.x);
          f_nxt.w = t17[15:0];
          f_nxt.x = '0;
        end
        if (e.y < 0) begin
          t17     = ext17(e.h) + ext17(e.y);
          f_nxt.h = t17[15:0];
          f_nxt.y = '0;
        end
        fok_nxt   = fok_nxt && (f_nxt.w > 0) && (f_nxt.h > 0);
        state_nxt = ST_FL2;
      end
      ST_FL2: begin
        if (out_free) begin
          g = f_r;
          if (ext17(f_r.x) + ext17(f_r.w) > bw) begin
            t17 = bw - ext17(f_r.x);
            g.w = t17[15:0];
          end
          if (ext17(f_r.y) + ext17(f_r.h) > bh) begin
            t17 = bh - ext17(f_r.y);
            g.h = t17[15:0];
          end
          ov_nxt    = 1'b1;
          ook_nxt   = fok_r && (g.w > 0) && (g.h > 0);
          od_nxt    = ook_nxt ? {g.h[14:0], g.w[14:0], g.y[14:0], g.x[14:0]} : '0;
          olast_nxt = (idx_r + 1'b1 == n_r);
          if (idx_r + 1'b1 == n_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = ST_FL1;
          end
        end
      end
      ST_FZERO: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ook_nxt   = 1'b0;
          od_nxt    = '0;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    j_r     <= j_nxt;
    n_r     <= n_nxt;
    cmd_r   <= cmd_nxt;
    d_r     <= d_nxt;
    tx2_r   <= tx2_nxt;
    ty2_r   <= ty2_nxt;
    f_r     <= f_nxt;
    fok_r   <= fok_nxt;
    od_r    <= od_nxt;
    ook_r   <= ook_nxt;
    olast_r <= olast_nxt;
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_RECTS))
    else $error("rectangle count above list size");
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_head.flush) |=> (count_r == '0))
    else $error("flush did not empty the list");
  a_move_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOVE) |-> (j_r <= count_r))
    else $error("slot refill beyond list end");
  a_out_only_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (!ov_r && ov_nxt) |-> (state_r == ST_FL2 || state_r == ST_FZERO))
    else $error("result raised outside a flush");
`endif

endmodule

// ----- hdl/dirty_rect_tracker.sv -----
// ----------------------------------------------------------------------------
// dirty_rect_tracker - dirty rectangle list for display refresh
// Collects invalidated screen rectangles and emits the merged list on flush.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per transaction. in_tuser 0 invalidates the rectangle
//           in in_tdata, 1 flushes the list. Invalidates produce no result.
//   out_* : a flush returns one transaction per stored rectangle (or one empty
//           one when the list is empty or the block is disabled); out_tlast
//           marks the final one, out_tuser says whether it is to be sent.
//   cfg_* : write enable, screen and frame buffer sizes while idle.
// Timing: the intake clips an invalidate in the accept cycle and queues it;
//   the list sequencer then walks the stored entries one per cycle, with
//   one extra refill step per absorbed entry, and collapses a full list
//   (N up to 8) into one entry. A flush emits each result in two steps
//   (read-and-clip, then edge clip into the output register), held while
//   the output stalls. The single read port on the store sets this pace.
// Reset: list emptied, enable 0, sizes 320x240. The store itself is not
//   cleared; only entries below the count are read.
// Stall: a held output stalls the sequencer; the two-entry queue keeps
//   accepting requests until it fills, then in_tready drops.
// ----------------------------------------------------------------------------
module dirty_rect_tracker import drt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // in_x, in_y, in_w, in_h
  input  logic        in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // rect_x, rect_y, rect_w, rect_h, zero pad
  output logic        out_tuser,  // rect_valid
  output logic        out_tlast,  // last
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [14:0] cfg_wdata
);

  cfg_t cfg_r;
  logic q_full, q_push, q_nonempty, q_pop;
  cmd_t q_cmd, q_head;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable   <= 1'b0;
      cfg_r.screen_w <= 15'd320;
      cfg_r.screen_h <= 15'd240;
      cfg_r.buf_w    <= 15'd320;
      cfg_r.buf_h    <= 15'd240;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ENABLE:   cfg_r.enable   <= cfg_wdata[0];
        CFG_SCREEN_W: cfg_r.screen_w <= cfg_wdata;
        CFG_SCREEN_H: cfg_r.screen_h <= cfg_wdata;
        CFG_BUF_W:    cfg_r.buf_w    <= cfg_wdata;
        CFG_BUF_H:    cfg_r.buf_h    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  drt_front u_front (
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  drt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .nonempty (q_nonempty),
    .pop      (q_pop),
    .head     (q_head)
  );

  drt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- tb/tb_dirty_rect_tracker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dirty_rect_tracker - self-checking bench for the dirty rectangle tracker
// Walks a directed table (clipping limits, empty and wrapped rectangles,
// merge and absorb, list overflow collapse, flushes), then random traffic
// under several screen and frame buffer sizes. Each flush result is checked
// against an in-bench model of the list, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_dirty_rect_tracker;
  import drt_pkg::*;

  localparam int WDOG_LIMIT = 4000;
  localparam int DRAIN_GAP  = 80;   // worst invalidate walk plus queue depth
  localparam int HOLD_LEN   = 300;

  typedef struct {
    logic [14:0] rx;
    logic [14:0] ry;
    logic [14:0] rw;
    logic [14:0] rh;
    logic        vld;
    logic        lst;
  } flush_rect_t;

  typedef struct {
    logic               op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    bit                 typed;
    flush_rect_t        e;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // in_x, in_y, in_w, in_h
  logic        in_tuser;   // req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // rect_x, rect_y, rect_w, rect_h, zero pad
  logic        out_tuser;  // rect_valid
  logic        out_tlast;  // last
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [14:0] cfg_wdata;

  // model of the list and of the registers
  int rx_s [MAX_RECTS];
  int ry_s [MAX_RECTS];
  int rw_s [MAX_RECTS];
  int rh_s [MAX_RECTS];
  int rect_cnt;
  int m_enable, m_scr_w, m_scr_h, m_buf_w, m_buf_h;

  flush_rect_t pending_rects[$];
  flush_rect_t fresh_rects[$];
  flush_rect_t typed_rects[$];

  int  errors, n_items, n_results, n_flushes, n_valid;
  bit  idle_on;
  bit  hold_req;
  int  hold_cnt;
  int  wdog;

  dirty_rect_tracker DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  function automatic int wrap16(int v);
    logic signed [15:0] t;
    t = v[15:0];
    return t;
  endfunction

  function automatic int imin(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int imax(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic bit overlaps(int i, int x, int y, int x2, int y2);
    return !(x > rx_s[i] + rw_s[i] || x2 < rx_s[i] ||
             y > ry_s[i] + rh_s[i] || y2 < ry_s[i]);
  endfunction

  function automatic void enlarge(int i, int x, int y, int x2, int y2);
    int nx1, ny1, nx2, ny2;
    nx1 = imin(x, rx_s[i]);
    ny1 = imin(y, ry_s[i]);
    nx2 = wrap16(imax(x2, rx_s[i] + rw_s[i]));
    ny2 = wrap16(imax(y2, ry_s[i] + rh_s[i]));
    rx_s[i] = nx1;
    ry_s[i] = ny1;
    rw_s[i] = wrap16(nx2 - nx1);
    rh_s[i] = wrap16(ny2 - ny1);
  endfunction

  function automatic void mark_dirty(int x, int y, int w, int h);
    int x2, y2, j, tx2, ty2, ex2, ey2;
    if (m_enable == 0 || w <= 0 || h <= 0) return;
    x2 = wrap16(x + w);
    y2 = wrap16(y + h);
    if (x < 0) x = 0;
    if (y < 0) y = 0;
    if (x2 > m_scr_w) x2 = m_scr_w;
    if (y2 > m_scr_h) y2 = m_scr_h;
    w = wrap16(x2 - x);
    h = wrap16(y2 - y);
    if (w <= 0 || h <= 0) return;
    for (int i = 0; i < rect_cnt; i++) begin
      if (!overlaps(i, x, y, x2, y2)) continue;
      enlarge(i, x, y, x2, y2);
      j = i + 1;
      while (j < rect_cnt) begin
        if (!overlaps(j, rx_s[i], ry_s[i], rx_s[i] + rw_s[i], ry_s[i] + rh_s[i])) begin
          j++;
          continue;
        end
        enlarge(i, rx_s[j], ry_s[j], rx_s[j] + rw_s[j], ry_s[j] + rh_s[j]);
        rect_cnt--;
        rx_s[j] = rx_s[rect_cnt];
        ry_s[j] = ry_s[rect_cnt];
        rw_s[j] = rw_s[rect_cnt];
        rh_s[j] = rh_s[rect_cnt];
      end
      return;
    end
    if (rect_cnt < MAX_RECTS) begin
      rx_s[rect_cnt] = x;
      ry_s[rect_cnt] = y;
      rw_s[rect_cnt] = w;
      rh_s[rect_cnt] = h;
      rect_cnt++;
      return;
    end
    // full list: collapse everything into one bounding box
    tx2 = wrap16(rx_s[0] + rw_s[0]);
    ty2 = wrap16(ry_s[0] + rh_s[0]);
    for (int i = 1; i < rect_cnt; i++) begin
      ex2 = wrap16(rx_s[i] + rw_s[i]);
      ey2 = wrap16(ry_s[i] + rh_s[i]);
      if (rx_s[i] < rx_s[0]) rx_s[0] = rx_s[i];
      if (ry_s[i] < ry_s[0]) ry_s[0] = ry_s[i];
      if (ex2 > tx2) tx2 = ex2;
      if (ey2 > ty2) ty2 = ey2;
    end
    if (x < rx_s[0]) rx_s[0] = x;
    if (y < ry_s[0]) ry_s[0] = y;
    if (x2 > tx2) tx2 = x2;
    if (y2 > ty2) ty2 = y2;
    rw_s[0] = wrap16(tx2 - rx_s[0]);
    rh_s[0] = wrap16(ty2 - ry_s[0]);
    rect_cnt = 1;
  endfunction

  function automatic void flush_list();
    int n, x0, y0, w, h;
    bit ok;
    flush_rect_t r;
    n = rect_cnt;
    rect_cnt = 0;
    if (n == 0 || m_enable == 0) begin
      r = '{0, 0, 0, 0, 1'b0, 1'b1};
      fresh_rects.push_back(r);
      return;
    end
    for (int i = 0; i < n; i++) begin
      x0 = rx_s[i]; y0 = ry_s[i]; w = rw_s[i]; h = rh_s[i];
      ok = (w > 0 && h > 0);
      if (ok) begin
        if (x0 < 0) begin w = wrap16(w + x0); x0 = 0; end
        if (y0 < 0) begin h = wrap16(h + y0); y0 = 0; end
        ok = (w > 0 && h > 0);
      end
      if (ok) begin
        if (x0 + w > m_buf_w) w = wrap16(m_buf_w - x0);
        if (y0 + h > m_buf_h) h = wrap16(m_buf_h - y0);
        ok = (w > 0 && h > 0);
      end
      r.rx  = ok ? x0[14:0] : '0;
      r.ry  = ok ? y0[14:0] : '0;
      r.rw  = ok ? w[14:0] : '0;
      r.rh  = ok ? h[14:0] : '0;
      r.vld = ok;
      r.lst = (i + 1 == n);
      fresh_rects.push_back(r);
    end
  endfunction

  // ------------------------------------------------------------- monitor
  // Sample every handshake at the clock edge; feed the model in order.
  always @(posedge clk) begin
    flush_rect_t e;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_ENABLE:   m_enable = cfg_wdata[0];
          CFG_SCREEN_W: m_scr_w  = cfg_wdata;
          CFG_SCREEN_H: m_scr_h  = cfg_wdata;
          CFG_BUF_W:    m_buf_w  = cfg_wdata;
          CFG_BUF_H:    m_buf_h  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        n_items++;
        if (in_tuser == REQ_FLUSH) begin
          n_flushes++;
          flush_list();
          // a typed row replaces the model's single result
          if (typed_rects.size() > 0) begin
            fresh_rects.delete();
            fresh_rects.push_back(typed_rects.pop_front());
          end
          while (fresh_rects.size() > 0) pending_rects.push_back(fresh_rects.pop_front());
        end else begin
          mark_dirty($signed(in_tdata[15:0]), $signed(in_tdata[31:16]),
                     $signed(in_tdata[47:32]), $signed(in_tdata[63:48]));
        end
      end
      if (out_tvalid && out_tready) begin
        n_results++;
        if (pending_rects.size() == 0) begin
          $error("unexpected result transaction");
          errors++;
        end else begin
          e = pending_rects.pop_front();
          if (out_tuser) n_valid++;
          if (out_tdata[14:0] !== e.rx) begin
            $error("rect_x exp %0d got %0d", e.rx, out_tdata[14:0]); errors++;
          end
          if (out_tdata[29:15] !== e.ry) begin
            $error("rect_y exp %0d got %0d", e.ry, out_tdata[29:15]); errors++;
          end
          if (out_tdata[44:30] !== e.rw) begin
            $error("rect_w exp %0d got %0d", e.rw, out_tdata[44:30]); errors++;
          end
          if (out_tdata[59:45] !== e.rh) begin
            $error("rect_h exp %0d got %0d", e.rh, out_tdata[59:45]); errors++;
          end
          if (out_tuser !== e.vld) begin
            $error("rect_valid exp %0d got %0d", e.vld, out_tuser); errors++;
          end
          if (out_tlast !== e.lst) begin
            $error("last exp %0d got %0d", e.lst, out_tlast); errors++;
          end
        end
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (hold_req && hold_cnt == 0) begin
        hold_cnt = HOLD_LEN;
        hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(idle_on && $urandom_range(99) < 24);
      end
    end
  end

  // Watchdog: count cycles in which no transaction of any kind moves.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we ||
        hold_cnt > 0) begin
      wdog = 0;
    end else begin
      wdog++;
      if (wdog > WDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------- driving
  task automatic send_req(logic op, logic signed [15:0] x, logic signed [15:0] y,
                          logic signed [15:0] w, logic signed [15:0] h);
    while (idle_on && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {h, w, y, x};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Let every flush result arrive, then cover any invalidate still walking.
  task automatic drain();
    while (pending_rects.size() > 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [14:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sizes(int sw, int sh, int bw, int bh);
    write_reg(CFG_SCREEN_W, sw[14:0]);
    write_reg(CFG_SCREEN_H, sh[14:0]);
    write_reg(CFG_BUF_W, bw[14:0]);
    write_reg(CFG_BUF_H, bh[14:0]);
  endtask

  // Mostly small rectangles near the screen so they merge; some raw noise.
  task automatic random_traffic(int count);
    int r, span_x, span_y;
    logic signed [15:0] x, y, w, h;
    span_x = imin(imax(m_scr_w, 16), 400);
    span_y = imin(imax(m_scr_h, 16), 300);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 12) begin
        send_req(REQ_FLUSH, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else if (r < 24) begin
        send_req(REQ_INVAL, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        x = 16'($urandom_range(span_x + 20) - 20);
        y = 16'($urandom_range(span_y + 20) - 20);
        w = 16'($urandom_range(60) - 2);
        h = 16'($urandom_range(60) - 2);
        send_req(REQ_INVAL, x, y, w, h);
      end
    end
    send_req(REQ_FLUSH, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    stop_sending();
  endtask

  row_t dir_rows[$];

  task automatic add_row(logic op, int x, int y, int w, int h, bit typed = 0,
                         flush_rect_t e = '{0, 0, 0, 0, 0, 0});
    row_t rw;
    rw.op = op; rw.x = 16'(x); rw.y = 16'(y); rw.w = 16'(w); rw.h = 16'(h);
    rw.typed = typed; rw.e = e;
    dir_rows.push_back(rw);
  endtask

  task automatic run_rows();
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) typed_rects.push_back(dir_rows[i].e);
      send_req(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].w, dir_rows[i].h);
    end
    stop_sending();
    dir_rows.delete();
  endtask

  // ------------------------------------------------------------ main flow
  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = 1'b0;
    cfg_we = 1'b0; cfg_addr = '0; cfg_wdata = '0;
    errors = 0; n_items = 0; n_results = 0; n_flushes = 0; n_valid = 0;
    idle_on = 1'b1; hold_req = 1'b0; wdog = 0;
    rect_cnt = 0; m_enable = 0;
    m_scr_w = 320; m_scr_h = 240; m_buf_w = 320; m_buf_h = 240;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled after reset: flushes come back empty, invalidates are dropped
    add_row(REQ_FLUSH, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1});
    add_row(REQ_INVAL, 10, 10, 20, 20);
    add_row(REQ_FLUSH, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1});
    run_rows();
    drain();
    write_reg(CFG_ENABLE, 15'd1);

    add_row(REQ_INVAL, 10, 20, 30, 40);
    add_row(REQ_FLUSH, 0, 0, 0, 0, 1, '{10, 20, 30, 40, 1, 1});
    add_row(REQ_FLUSH, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1});          // empty list
    add_row(REQ_INVAL, -32768, -32768, 32767, 32767);                 // far edge at -1, dropped
    add_row(REQ_INVAL, 32767, 32767, 1, 1);                           // wraps negative
    add_row(REQ_INVAL, 0, 0, 0, 5);                                   // zero width
    add_row(REQ_INVAL, 0, 0, 5, -1);                                  // negative height
    add_row(REQ_INVAL, 0, 0, -32768, 32767);
    add_row(REQ_INVAL, -5, -5, 20, 20);                               // clipped at origin
    add_row(REQ_INVAL, 15, 0, 10, 10);                                // touches first
    add_row(REQ_INVAL, 100, 100, 10, 10);
    add_row(REQ_INVAL, 50, 50, 60, 60);                               // grows the second entry
    add_row(REQ_INVAL, 300, 200, 100, 100);                           // clipped at far edge
    add_row(REQ_FLUSH, 0, 0, 0, 0);
    for (int k = 0; k < 9; k++) add_row(REQ_INVAL, k * 35, 0, 10, 10); // overflow collapse
    add_row(REQ_FLUSH, 0, 0, 0, 0);
    run_rows();
    drain();

    // random phases under different sizes, the extremes among them
    set_sizes(32767, 32767, 0, 0);
    random_traffic(30);
    drain();
    set_sizes(0, 0, 32767, 32767);
    random_traffic(20);
    drain();
    set_sizes(64, 48, 40, 60);
    idle_on = 1'b0;                   // a stretch with no idling at all
    random_traffic(40);
    drain();
    idle_on = 1'b1;
    set_sizes(32767, 32767, 32767, 32767);
    random_traffic(30);
    drain();
    set_sizes(320, 240, 320, 240);
    hold_req = 1'b1;                  // long receiver hold-off to fill the block
    random_traffic(50);
    drain();
    set_sizes($urandom_range(32767), $urandom_range(32767),
              $urandom_range(32767), $urandom_range(32767));
    random_traffic(30);
    drain();
    set_sizes(100, 80, 90, 70);
    random_traffic(40);
    drain();
    write_reg(CFG_ENABLE, 15'd0);
    random_traffic(15);
    drain();

    $display("Covered %0d requests, %0d flushes, %0d results (%0d marked valid).",
             n_items, n_flushes, n_results, n_valid);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
